FILE: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// Slot count, derived widths, item structs, command structs and the sequencer
// state encoding used by the list, slot store and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

	// Number of timer slots and derived widths
	localparam int NUM_TIMERS = 16;
	localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int ID_W       = 4;
	localparam int KIND_W     = 2;
	localparam int DUR_W      = 32;
	localparam int TIME_W     = 64;

	// Operation codes carried in the kind field
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   timer_id;
		logic [DUR_W-1:0]  duration_ms;
		logic [TIME_W-1:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] expired_id;
		logic            last_expiry;
	} out_item_t;

	// Order list operations
	typedef enum logic [1:0] {
		LST_NOP,
		LST_REMOVE,
		LST_INSERT
	} list_op_t;

	typedef struct packed {
		list_op_t          op;
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W-1:0] id;
	} list_cmd_t;

	// Slot store writes
	typedef struct packed {
		logic              dl_we;
		logic              act_set;
		logic              act_clr;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] deadline;
	} slot_cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_INSERT,
		ST_TICK
	} state_t;

endpackage

`default_nettype wire

FILE: src/stq_list.sv
// ----------------------------------------------------------------------------
// stq_list: deadline-ordered list of active timer ids
// Holds the ids in list order plus a fill count; removes or inserts one entry
// per cycle by shifting the tail, and reads one entry at a chosen position.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_list (
	input  wire                       clk,
	input  wire                       arst_n,
	input  stq_pkg::list_cmd_t        cmd,
	input  wire  [stq_pkg::SLOT_W-1:0] rd_pos,
	output logic [stq_pkg::SLOT_W-1:0] rd_id,
	output logic [stq_pkg::CNT_W-1:0]  count
);
	import stq_pkg::*;

	logic [SLOT_W-1:0] entry_q [NUM_TIMERS];
	logic [CNT_W-1:0]  count_q;

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				LST_REMOVE: count_q <= count_q - CNT_W'(1);
				LST_INSERT: count_q <= count_q + CNT_W'(1);
				default:    count_q <= count_q;
			endcase
		end
	end

	// Entries: shift tail down on remove, up on insert
	always_ff @(posedge clk) begin
		case (cmd.op)
			LST_REMOVE: begin
				for (int i = 0; i < NUM_TIMERS - 1; i++) begin
					if (i >= int'(cmd.pos)) begin
						entry_q[i] <= entry_q[i+1];
					end
				end
			end
			LST_INSERT: begin
				for (int i = 1; i < NUM_TIMERS; i++) begin
					if (i > int'(cmd.pos)) begin
						entry_q[i] <= entry_q[i-1];
					end
				end
				entry_q[cmd.pos] <= cmd.id;
			end
			default: ;
		endcase
	end

	assign rd_id = entry_q[rd_pos];
	assign count = count_q;

endmodule

`default_nettype wire

FILE: src/stq_slots.sv
// ----------------------------------------------------------------------------
// stq_slots: per-slot deadline and active flag store
// Deadlines are written on insertion only; active flags reset to zero.
// One deadline read and one flag read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_slots (
	input  wire                        clk,
	input  wire                        arst_n,
	input  stq_pkg::slot_cmd_t         cmd,
	input  wire  [stq_pkg::SLOT_W-1:0] rd_slot,
	output logic [stq_pkg::TIME_W-1:0] rd_deadline,
	input  wire  [stq_pkg::SLOT_W-1:0] chk_slot,
	output logic                       chk_active
);
	import stq_pkg::*;

	logic [TIME_W-1:0]     deadline_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] active_q;

	// Active flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.act_set) begin
			active_q[cmd.slot] <= 1'b1;
		end else if (cmd.act_clr) begin
			active_q[cmd.slot] <= 1'b0;
		end
	end

	// Deadlines
	always_ff @(posedge clk) begin
		if (cmd.dl_we) begin
			deadline_q[cmd.slot] <= cmd.deadline;
		end
	end

	assign rd_deadline = deadline_q[rd_slot];
	assign chk_active  = active_q[chk_slot];

endmodule

`default_nettype wire

FILE: src/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue: deadline-sorted timer queue
// Starts, cancels and ticks timers kept in a list sorted by deadline; a tick
// drains every expired timer from the list head, one result item each.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | carries
//  --------+-------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_item   | kind, timer_id, duration, now
//  out     | out_valid, out_ready, out_item| expired_id, last_expiry
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Start: accept, then walk up to N entries to find and unlink an active timer,
// then deadline compares over up to N entries to find the insert point (N slots).
// Tick: remove each expired timer from the list head, then see the first live
// head; all steps share one 64-bit compare. Results leave through an output
// register, so a stalled out_ready only holds the tick drain. Reset clears the
// active flags, list count, state, hold valid and output valid; no clearing pass is needed.
`default_nettype none

module sorted_timer_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  stq_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output stq_pkg::out_item_t   out_item
);
	import stq_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [SLOT_W-1:0] id_q, id_d;
	logic              start_q, start_d;
	logic [TIME_W-1:0] key_q, key_d;
	logic [SLOT_W-1:0] hold_q, hold_d;
	logic              hold_vld_q, hold_vld_d;
	logic              out_valid_q, out_valid_d;
	out_item_t         out_q, out_d;

	list_cmd_t         lst_cmd;
	slot_cmd_t         slot_cmd;
	logic [SLOT_W-1:0] lst_rd_id;
	logic [CNT_W-1:0]  lst_count;
	logic [TIME_W-1:0] rd_deadline;
	logic              chk_active;

	logic              le;
	logic              listed;
	logic              in_range;
	logic              out_free;
	logic              expired;

	stq_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lst_cmd),
		.rd_pos (pos_q[SLOT_W-1:0]),
		.rd_id  (lst_rd_id),
		.count  (lst_count)
	);

	stq_slots u_slots (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (slot_cmd),
		.rd_slot     (lst_rd_id),
		.rd_deadline (rd_deadline),
		.chk_slot    (SLOT_W'(in_item.timer_id)),
		.chk_active  (chk_active)
	);

	// Shared compare: listed deadline against the key (new deadline or now)
	assign le       = rd_deadline <= key_q;
	assign listed   = pos_q < lst_count;
	assign in_range = int'(in_item.timer_id) < NUM_TIMERS;
	assign out_free = !out_valid_q || out_ready;
	assign expired  = listed && le;

	// State and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hold_vld_q  <= hold_vld_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		id_q    <= id_d;
		start_q <= start_d;
		key_q   <= key_d;
		hold_q  <= hold_d;
		out_q   <= out_d;
	end

	// Sequencer
	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		id_d        = id_q;
		start_d     = start_q;
		key_d       = key_q;
		hold_d      = hold_q;
		hold_vld_d  = hold_vld_q;
		out_valid_d = out_valid_q && !out_ready;
		out_d       = out_q;
		lst_cmd     = '{op: LST_NOP, pos: '0, id: '0};
		slot_cmd    = '{dl_we: 1'b0, act_set: 1'b0, act_clr: 1'b0, slot: '0, deadline: '0};
		in_ready    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					id_d    = SLOT_W'(in_item.timer_id);
					pos_d   = '0;
					start_d = in_item.kind == KIND_START;
					key_d   = (in_item.kind == KIND_START)
						? in_item.now_ticks + TIME_W'(in_item.duration_ms)
						: in_item.now_ticks;
					if ((in_item.kind == KIND_START || in_item.kind == KIND_CANCEL)
						&& in_range) begin
						if (chk_active) begin
							state_d = ST_DROP;
						end else if (in_item.kind == KIND_START) begin
							state_d = ST_INSERT;
						end
					end else if (in_item.kind == KIND_TICK) begin
						state_d = ST_TICK;
					end
				end
			end

			// Walk the list to unlink the addressed timer
			ST_DROP: begin
				if (lst_rd_id == id_q) begin
					lst_cmd          = '{op: LST_REMOVE, pos: pos_q[SLOT_W-1:0], id: id_q};
					slot_cmd.act_clr = 1'b1;
					slot_cmd.slot    = id_q;
					pos_d            = '0;
					state_d          = start_q ? ST_INSERT : ST_IDLE;
				end else begin
					pos_d = pos_q + CNT_W'(1);
				end
			end

			// Skip entries due at or before the new deadline, then link it in
			ST_INSERT: begin
				if (expired) begin
					pos_d = pos_q + CNT_W'(1);
				end else begin
					lst_cmd           = '{op: LST_INSERT, pos: pos_q[SLOT_W-1:0], id: id_q};
					slot_cmd.dl_we    = 1'b1;
					slot_cmd.act_set  = 1'b1;
					slot_cmd.slot     = id_q;
					slot_cmd.deadline = key_q;
					state_d           = ST_IDLE;
				end
			end

			// Drain expired heads; one held back until the next head is known
			ST_TICK: begin
				if (hold_vld_q) begin
					if (out_free) begin
						out_valid_d = 1'b1;
						out_d       = '{expired_id: ID_W'(hold_q), last_expiry: !expired};
						if (expired) begin
							hold_d           = lst_rd_id;
							lst_cmd          = '{op: LST_REMOVE, pos: '0, id: lst_rd_id};
							slot_cmd.act_clr = 1'b1;
							slot_cmd.slot    = lst_rd_id;
						end else begin
							hold_vld_d = 1'b0;
							state_d    = ST_IDLE;
						end
					end
				end else if (expired) begin
					hold_d           = lst_rd_id;
					hold_vld_d       = 1'b1;
					lst_cmd          = '{op: LST_REMOVE, pos: '0, id: lst_rd_id};
					slot_cmd.act_clr = 1'b1;
					slot_cmd.slot    = lst_rd_id;
				end else begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
